// File: sv/mcfd_pkg.sv
// ----------------------------------------------------------------------------
// mcfd_pkg
// Shared types and constants of the motor command frame decoder.
// ----------------------------------------------------------------------------
package mcfd_pkg;

  // ASCII codes that appear in a command frame.
  localparam logic [7:0] ChE    = 8'h45;
  localparam logic [7:0] ChF    = 8'h46;
  localparam logic [7:0] ChB    = 8'h42;
  localparam logic [7:0] ChR    = 8'h52;
  localparam logic [7:0] ChL    = 8'h4C;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChOne  = 8'h31;

  // Digit weights.
  localparam logic [7:0] WeightHundreds = 8'd100;
  localparam logic [7:0] WeightTens     = 8'd10;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxAngle = 2'd1;
  localparam logic [7:0] MaxSpeedReset = 8'd100;
  localparam logic [6:0] MaxAngleReset = 7'd45;

  // Byte positions inside a frame.
  localparam logic [2:0] PosSpeedHi  = 3'd0;
  localparam logic [2:0] PosSpeedMid = 3'd1;
  localparam logic [2:0] PosSpeedLo  = 3'd2;
  localparam logic [2:0] PosDrive    = 3'd3;
  localparam logic [2:0] PosAngleHi  = 3'd4;
  localparam logic [2:0] PosAngleLo  = 3'd5;
  localparam logic [2:0] PosStepDir  = 3'd6;
  localparam logic [2:0] PosTerm     = 3'd7;

  // Frame summary handed from the assembler to the step calculator and top.
  typedef struct packed {
    logic       ends;
    logic       good;
    logic [7:0] speed;
    logic       drive_b;
    logic [6:0] angle;
    logic       dir_right;
  } frame_t;

  // Stepper move and the angle status after the frame.
  typedef struct packed {
    logic [7:0] count;
    logic       right;
    logic [6:0] shown_angle;
    logic       angle_negative;
  } step_t;

endpackage

// File: sv/mcfd_frame_asm.sv
// ----------------------------------------------------------------------------
// mcfd_frame_asm
// Tracks the byte position, accumulates the speed and angle digits and checks
// the frame syntax and limits.
// ----------------------------------------------------------------------------
module mcfd_frame_asm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         byte_i,
  input  logic [7:0]         max_speed_i,
  input  logic [6:0]         max_angle_i,
  output mcfd_pkg::frame_t   frame_o
);

  logic [2:0] pos_q, pos_d;
  logic [7:0] speed_q, speed_d;
  logic [7:0] angle_q, angle_d;
  logic       drive_q, drive_d;
  logic       dir_q, dir_d;
  logic       err_q, err_d;
  logic [7:0] dig;
  logic       ends;

  assign dig  = byte_i - mcfd_pkg::ChZero;
  assign ends = (byte_i == mcfd_pkg::ChE) || (pos_q == mcfd_pkg::PosTerm);

  always_comb begin
    pos_d   = pos_q;
    speed_d = speed_q;
    angle_d = angle_q;
    drive_d = drive_q;
    dir_d   = dir_q;
    err_d   = err_q;
    if (fire_i) begin
      if (ends) begin
        pos_d   = mcfd_pkg::PosSpeedHi;
        speed_d = '0;
        angle_d = '0;
        drive_d = 1'b0;
        dir_d   = 1'b0;
        err_d   = 1'b0;
      end else begin
        pos_d = pos_q + 3'd1;
        case (pos_q)
          mcfd_pkg::PosSpeedHi: begin
            if ((byte_i == mcfd_pkg::ChZero) || (byte_i == mcfd_pkg::ChOne)) begin
              speed_d = dig * mcfd_pkg::WeightHundreds;
            end else begin
              err_d = 1'b1;
            end
          end
          mcfd_pkg::PosSpeedMid: speed_d = speed_q + dig * mcfd_pkg::WeightTens;
          mcfd_pkg::PosSpeedLo:  speed_d = speed_q + dig;
          mcfd_pkg::PosDrive: begin
            if (byte_i == mcfd_pkg::ChB) begin
              drive_d = 1'b1;
            end else if (byte_i == mcfd_pkg::ChF) begin
              drive_d = 1'b0;
            end else begin
              err_d = 1'b1;
            end
          end
          mcfd_pkg::PosAngleHi: angle_d = dig * mcfd_pkg::WeightTens;
          mcfd_pkg::PosAngleLo: angle_d = angle_q + dig;
          mcfd_pkg::PosStepDir: begin
            if (byte_i == mcfd_pkg::ChR) begin
              dir_d = 1'b1;
            end else if (byte_i == mcfd_pkg::ChL) begin
              dir_d = 1'b0;
            end else begin
              err_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= mcfd_pkg::PosSpeedHi;
      speed_q <= '0;
      angle_q <= '0;
      drive_q <= 1'b0;
      dir_q   <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      speed_q <= speed_d;
      angle_q <= angle_d;
      drive_q <= drive_d;
      dir_q   <= dir_d;
      err_q   <= err_d;
    end
  end

  // A frame is only good when it runs to the last position and ends on the
  // terminator; the digit fields are complete by then.
  always_comb begin
    frame_o.ends      = ends;
    frame_o.good      = (pos_q == mcfd_pkg::PosTerm) && (byte_i == mcfd_pkg::ChE) &&
                        !err_q && (speed_q <= max_speed_i) &&
                        (angle_q <= {1'b0, max_angle_i});
    frame_o.speed     = speed_q;
    frame_o.drive_b   = drive_q;
    frame_o.angle     = angle_q[6:0];
    frame_o.dir_right = dir_q;
  end

endmodule

// File: sv/mcfd_step_calc.sv
// ----------------------------------------------------------------------------
// mcfd_step_calc
// Holds the stored stepper angle and direction marks and works out the
// stepper move of an executed frame.
// ----------------------------------------------------------------------------
module mcfd_step_calc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               execute_i,
  input  mcfd_pkg::frame_t   frame_i,
  output mcfd_pkg::step_t    step_o
);

  logic [6:0] stored_q;
  logic       right_q;
  logic       left_q;
  logic       same_dir;
  logic       ge;

  assign same_dir = frame_i.dir_right ? right_q : left_q;
  assign ge       = (frame_i.angle >= stored_q);

  always_comb begin
    if (same_dir) begin
      step_o.count = ge ? {1'b0, frame_i.angle - stored_q} : {1'b0, stored_q - frame_i.angle};
      step_o.right = frame_i.dir_right ? ge : !ge;
    end else begin
      step_o.count = {1'b0, frame_i.angle} + {1'b0, stored_q};
      step_o.right = frame_i.dir_right;
    end
    step_o.shown_angle    = execute_i ? frame_i.angle : stored_q;
    step_o.angle_negative = execute_i ? !frame_i.dir_right : left_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      right_q  <= 1'b0;
      left_q   <= 1'b0;
    end else if (execute_i) begin
      stored_q <= frame_i.angle;
      right_q  <= frame_i.dir_right;
      left_q   <= !frame_i.dir_right;
    end
  end

endmodule

// File: sv/motor_command_frame_decoder.sv
// ----------------------------------------------------------------------------
// motor_command_frame_decoder
// Assembles ASCII motor command frames of up to 8 bytes; one result per frame.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  rx       in         rx_valid_i/rx_stall_o  rx_byte_i
//  res      out        res_valid_o/res_stall_i frame_ok_o, speed_o, drive_clockwise_o,
//                                             step_count_o, step_right_o,
//                                             shown_angle_o, angle_negative_o
//  cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A byte enters the input register when accepted; it is decoded, and a
// frame-ending byte's result registered, once the result register can take
// one. One item is taken per cycle unless the result side stalls, set by the
// single decode step between the two registers. Reset clears the frame state,
// the stored angle and direction marks, and loads the limits with 100 and 45.
// A stall on a full result register holds it, the buffered byte and rx side.
//
module motor_command_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Byte input channel.
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  // Result channel.
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic       frame_ok_o,
  output logic [7:0] speed_o,
  output logic       drive_clockwise_o,
  output logic [7:0] step_count_o,
  output logic       step_right_o,
  output logic [6:0] shown_angle_o,
  output logic       angle_negative_o,
  // Configuration write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [mcfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  // Configuration registers.
  logic [7:0] max_speed_q;
  logic [6:0] max_angle_q;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Result register.
  logic       out_valid_q, out_valid_d;
  logic       ok_q;
  logic [7:0] speed_q;
  logic       drive_q;
  logic [7:0] count_q;
  logic       right_q;
  logic [6:0] shown_q;
  logic       neg_q;

  logic out_ready;
  logic in_ready;
  logic fire;
  logic execute;

  mcfd_pkg::frame_t frame;
  mcfd_pkg::step_t  step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= mcfd_pkg::MaxSpeedReset;
      max_angle_q <= mcfd_pkg::MaxAngleReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == mcfd_pkg::CfgMaxSpeed) begin
        max_speed_q <= cfg_data_i;
      end else if (cfg_index_i == mcfd_pkg::CfgMaxAngle) begin
        max_angle_q <= cfg_data_i[6:0];
      end
    end
  end

  // The result register can take a new result when it is empty or being
  // taken this cycle. The buffered byte is decoded whenever that holds, even
  // if it ends no frame, so the input side keeps flowing.
  assign out_ready  = !out_valid_q || !res_stall_i;
  assign fire       = in_valid_q && out_ready;
  assign in_ready   = !in_valid_q || out_ready;
  assign rx_stall_o = !in_ready;
  assign execute    = fire && frame.ends && frame.good;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  mcfd_frame_asm u_frame_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .max_speed_i (max_speed_q),
    .max_angle_i (max_angle_q),
    .frame_o     (frame)
  );

  mcfd_step_calc u_step_calc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .execute_i (execute),
    .frame_i   (frame),
    .step_o    (step)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = fire && frame.ends;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // A rejected frame reports zeros for the move and keeps the stored status.
  always_ff @(posedge clk_i) begin
    if (fire && frame.ends) begin
      ok_q    <= frame.good;
      speed_q <= frame.good ? frame.speed : 8'd0;
      drive_q <= frame.good && frame.drive_b;
      count_q <= frame.good ? step.count : 8'd0;
      right_q <= frame.good && step.right;
      shown_q <= step.shown_angle;
      neg_q   <= step.angle_negative;
    end
  end

  assign res_valid_o       = out_valid_q;
  assign frame_ok_o        = ok_q;
  assign speed_o           = speed_q;
  assign drive_clockwise_o = drive_q;
  assign step_count_o      = count_q;
  assign step_right_o      = right_q;
  assign shown_angle_o     = shown_q;
  assign angle_negative_o  = neg_q;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the motor command frame decoder. Bytes are fed one
// item at a time, and each frame result is checked against a cycle-free
// decoder model kept in the bench, while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Random bytes after the directed part, split evenly over the limit phases.
  localparam int RandomBytes = 1500;
  localparam int PhaseCount = 6;
  // Cycles allowed for a byte that ends no frame to leave the pipeline.
  localparam int SettleCycles = 8;
  // Bound on the wait for outstanding results at a phase boundary.
  localparam int DrainLimit = 2000;
  localparam int ShownErrors = 10;
  localparam int DirRows = 5;

  // One decoded frame as it appears on the result channel.
  typedef struct packed {
    logic       ok;
    logic [7:0] speed;
    logic       clockwise;
    logic [7:0] steps;
    logic       right;
    logic [6:0] angle;
    logic       negative;
  } frame_result_t;

  // One directed frame: the bytes are right aligned, the first byte highest.
  typedef struct packed {
    logic [3:0]    len;
    logic [63:0]   chars;
    logic          typed;
    frame_result_t want;
  } frame_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       rx_valid_i = 1'b0;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i = '0;
  logic       res_valid_o;
  logic       res_stall_i = 1'b0;
  logic       frame_ok_o;
  logic [7:0] speed_o;
  logic       drive_clockwise_o;
  logic [7:0] step_count_o;
  logic       step_right_o;
  logic [6:0] shown_angle_o;
  logic       angle_negative_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [mcfd_pkg::CfgIdxW-1:0] cfg_index_i = mcfd_pkg::CfgMaxSpeed;
  logic [7:0] cfg_data_i = '0;

  motor_command_frame_decoder dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_valid_i        (rx_valid_i),
    .rx_stall_o        (rx_stall_o),
    .rx_byte_i         (rx_byte_i),
    .res_valid_o       (res_valid_o),
    .res_stall_i       (res_stall_i),
    .frame_ok_o        (frame_ok_o),
    .speed_o           (speed_o),
    .drive_clockwise_o (drive_clockwise_o),
    .step_count_o      (step_count_o),
    .step_right_o      (step_right_o),
    .shown_angle_o     (shown_angle_o),
    .angle_negative_o  (angle_negative_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // Model copy of the decoder state. The limits start at their reset values.
  logic [7:0] lim_speed = mcfd_pkg::MaxSpeedReset;
  logic [6:0] lim_angle = mcfd_pkg::MaxAngleReset;
  logic [2:0] frame_pos = '0;
  logic [7:0] speed_sum = '0;
  logic       drive_b = 1'b0;
  logic [7:0] angle_sum = '0;
  logic       turn_right = 1'b0;
  logic       frame_bad = 1'b0;
  logic [6:0] held_angle = '0;
  logic       was_right = 1'b0;
  logic       was_left = 1'b0;

  // Frame results predicted but not yet seen on the result channel.
  frame_result_t pending_frames[$];
  frame_result_t seen_frame, due_frame;

  int  error_count = 0;
  int  rx_items = 0;
  // Toggled now and then, so that both sides also run stretches at full rate.
  bit  idle_on = 1'b1;
  int  stall_cycles;

  // Directed frames. The expected result is typed in where it follows from
  // the reset limits alone; the last row is left to the decoder model.
  frame_row_t frame_rows [DirRows] = '{
    // A terminator as the very first byte: empty frame, rejected.
    '{4'd1, "E", 1'b1, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 7'd0, 1'b0}},
    // Speed and angle right at the reset limits. The stepper had no
    // direction yet, so the move is the sum of both angles.
    '{4'd8, "100F45RE", 1'b1, '{1'b1, 8'd100, 1'b0, 8'd45, 1'b1, 7'd45, 1'b0}},
    // Bad first speed digit, followed by an early terminator.
    '{4'd2, "2E", 1'b1, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 7'd45, 1'b0}},
    // Byte extremes as digits and as the last byte: the terminator is
    // missing, the speed wraps above the limit and the angle is over it.
    '{4'd8, {"1", 8'h00, "1B46L", 8'hFF}, 1'b1,
      '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 7'd45, 1'b0}},
    // A good frame that reverses the stepper direction.
    '{4'd8, "050B10LE", 1'b0, '0}
  };

  initial begin
    forever #1ns clk_i = ~clk_i;
  end

  // Safety net against a hung handshake.
  initial begin
    #1ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void flag_error(input string msg);
    if (error_count < ShownErrors) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    error_count++;
  endfunction

  function automatic string show_frame(input frame_result_t r);
    return $sformatf("ok=%0d speed=%0d cw=%0d steps=%0d right=%0d angle=%0d neg=%0d",
                     r.ok, r.speed, r.clockwise, r.steps, r.right, r.angle,
                     r.negative);
  endfunction

  // Decoder model: consumes one byte and tells whether it ends a frame and,
  // if so, what result that frame gives. Digits are taken as (byte - '0')
  // mod 256, so any byte may stand in a digit slot.
  task automatic decode_rx_byte(input logic [7:0] b, output bit ends,
                                output frame_result_t r);
    logic [7:0] digit;
    logic [6:0] new_angle;
    logic       same_dir;
    bit         good;
    digit = b - mcfd_pkg::ChZero;
    ends = (b == mcfd_pkg::ChE) || (frame_pos == mcfd_pkg::PosTerm);
    r = '0;
    case (frame_pos)
      mcfd_pkg::PosSpeedHi: begin
        if (b == mcfd_pkg::ChZero || b == mcfd_pkg::ChOne) begin
          speed_sum = 8'd100 * digit;
        end else begin
          frame_bad = 1'b1;
        end
      end
      mcfd_pkg::PosSpeedMid: speed_sum = speed_sum + 8'd10 * digit;
      mcfd_pkg::PosSpeedLo:  speed_sum = speed_sum + digit;
      mcfd_pkg::PosDrive: begin
        if (b == mcfd_pkg::ChB) begin
          drive_b = 1'b1;
        end else if (b == mcfd_pkg::ChF) begin
          drive_b = 1'b0;
        end else begin
          frame_bad = 1'b1;
        end
      end
      mcfd_pkg::PosAngleHi: angle_sum = 8'd10 * digit;
      mcfd_pkg::PosAngleLo: angle_sum = angle_sum + digit;
      mcfd_pkg::PosStepDir: begin
        if (b == mcfd_pkg::ChR) begin
          turn_right = 1'b1;
        end else if (b == mcfd_pkg::ChL) begin
          turn_right = 1'b0;
        end else begin
          frame_bad = 1'b1;
        end
      end
      default: begin
        if (b != mcfd_pkg::ChE) begin
          frame_bad = 1'b1;
        end
      end
    endcase
    if (!ends) begin
      frame_pos = frame_pos + 3'd1;
    end else begin
      good = (frame_pos == mcfd_pkg::PosTerm) && !frame_bad &&
             (speed_sum <= lim_speed) && (angle_sum <= {1'b0, lim_angle});
      if (good) begin
        new_angle = angle_sum[6:0];
        same_dir = turn_right ? was_right : was_left;
        r.ok = 1'b1;
        r.speed = speed_sum;
        r.clockwise = drive_b;
        // Same direction as last time: move by the difference, and turn
        // back when the new angle is the smaller one. Otherwise the stepper
        // swings through zero, so the two angles add up.
        if (!same_dir) begin
          r.steps = {1'b0, new_angle} + {1'b0, held_angle};
          r.right = turn_right;
        end else if (new_angle >= held_angle) begin
          r.steps = {1'b0, new_angle - held_angle};
          r.right = turn_right;
        end else begin
          r.steps = {1'b0, held_angle - new_angle};
          r.right = !turn_right;
        end
        was_right = turn_right;
        was_left = !turn_right;
        held_angle = new_angle;
      end
      r.angle = held_angle;
      r.negative = was_left;
      frame_pos = '0;
      speed_sum = '0;
      drive_b = 1'b0;
      angle_sum = '0;
      turn_right = 1'b0;
      frame_bad = 1'b0;
    end
  endtask

  // Offers one byte item after a random gap and waits until it is taken.
  // Called and left just after a falling edge. A typed expectation, where
  // given, replaces the model's result for the frame that this byte ends.
  task automatic push_rx_byte(input logic [7:0] b, input bit typed,
                              input frame_result_t want);
    int            gap;
    bit            ends;
    frame_result_t r;
    if ($urandom_range(0, 99) == 0) begin
      idle_on = !idle_on;
    end
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    decode_rx_byte(b, ends, r);
    if (ends) begin
      pending_frames.push_back(typed ? want : r);
    end
    rx_items++;
    @(negedge clk_i);
  endtask

  // Stops the byte stream, lets every expected result come out, and then
  // gives a byte that ends no frame time to pass through the pipeline.
  task automatic drain_results();
    int waited;
    waited = 0;
    rx_valid_i <= 1'b0;
    while (pending_frames.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    while (pending_frames.size() != 0) begin
      flag_error({"no result for ", show_frame(pending_frames.pop_front())});
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes one limit register; only called while the decoder is idle.
  task automatic write_limit(input logic [mcfd_pkg::CfgIdxW-1:0] idx,
                             input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == mcfd_pkg::CfgMaxSpeed) begin
      lim_speed = value;
    end else if (idx == mcfd_pkg::CfgMaxAngle) begin
      lim_angle = value[6:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Most frames are well formed with random content, often kept inside the
  // limits so that good frames keep moving the stepper. The rest are frames
  // with one slot broken, cut short, or plain byte noise.
  task automatic send_random_frame();
    logic [7:0] fb [8];
    int         kind;
    int         count;
    int         spd;
    int         ang;
    int         slot;
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      count = $urandom_range(1, 8);
      for (int i = 0; i < count; i++) begin
        fb[0] = 8'($urandom_range(0, 255));
        if (i == count - 1 && $urandom_range(0, 1) == 1) begin
          fb[0] = mcfd_pkg::ChE;
        end
        push_rx_byte(fb[0], 1'b0, '0);
      end
    end else begin
      spd = $urandom_range(0, 1) ? $urandom_range(0, 199) : $urandom_range(0, lim_speed);
      ang = $urandom_range(0, 1) ? $urandom_range(0, 99) : $urandom_range(0, lim_angle);
      fb[0] = mcfd_pkg::ChZero + 8'(spd / 100);
      fb[1] = mcfd_pkg::ChZero + 8'((spd / 10) % 10);
      fb[2] = mcfd_pkg::ChZero + 8'(spd % 10);
      fb[3] = $urandom_range(0, 1) ? mcfd_pkg::ChB : mcfd_pkg::ChF;
      fb[4] = mcfd_pkg::ChZero + 8'(ang / 10);
      fb[5] = mcfd_pkg::ChZero + 8'(ang % 10);
      fb[6] = $urandom_range(0, 1) ? mcfd_pkg::ChR : mcfd_pkg::ChL;
      fb[7] = mcfd_pkg::ChE;
      // Now and then a digit slot carries any byte at all.
      if ($urandom_range(0, 7) == 0) begin
        slot = $urandom_range(0, 3);
        fb[slot < 2 ? slot + 1 : slot + 2] = 8'($urandom_range(0, 255));
      end
      count = 8;
      if (kind >= 6) begin
        slot = $urandom_range(0, 7);
        case ($urandom_range(0, 2))
          0:       fb[slot] = mcfd_pkg::ChE;
          1:       fb[slot] = 8'($urandom_range(0, 255));
          default: count = slot + 1;
        endcase
      end
      for (int i = 0; i < count; i++) begin
        push_rx_byte(fb[i], 1'b0, '0);
      end
    end
  endtask

  // Result side: while idle_on is set it holds stall high for a random number
  // of cycles before each result, then takes it as soon as it shows up.
  initial begin
    forever begin
      stall_cycles = idle_on ? $urandom_range(0, 7) : 0;
      if (stall_cycles > 0) begin
        res_stall_i <= 1'b1;
        repeat (stall_cycles) @(negedge clk_i);
      end
      res_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!res_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Every result taken is matched against the oldest predicted frame.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i) begin
      seen_frame = '{frame_ok_o, speed_o, drive_clockwise_o, step_count_o,
                     step_right_o, shown_angle_o, angle_negative_o};
      if (pending_frames.size() == 0) begin
        flag_error({"unexpected result ", show_frame(seen_frame)});
      end else begin
        due_frame = pending_frames.pop_front();
        if (seen_frame !== due_frame) begin
          flag_error({"expected ", show_frame(due_frame), " got ",
                      show_frame(seen_frame)});
        end
      end
    end
  end

  initial begin
    int target;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset limits.
    for (int r = 0; r < DirRows; r++) begin
      for (int i = 0; i < frame_rows[r].len; i++) begin
        push_rx_byte(frame_rows[r].chars[8 * (frame_rows[r].len - 1 - i) +: 8],
                     frame_rows[r].typed && (i == frame_rows[r].len - 1),
                     frame_rows[r].want);
      end
    end
    drain_results();

    // Random phases, each under its own pair of limits: the widest, the
    // tightest, mixed extremes and random picks.
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          write_limit(mcfd_pkg::CfgMaxSpeed, 8'd199);
          write_limit(mcfd_pkg::CfgMaxAngle, 8'd99);
        end
        1: begin
          write_limit(mcfd_pkg::CfgMaxSpeed, 8'd0);
          write_limit(mcfd_pkg::CfgMaxAngle, 8'd0);
        end
        2: begin
          write_limit(mcfd_pkg::CfgMaxSpeed, 8'd199);
          write_limit(mcfd_pkg::CfgMaxAngle, 8'd0);
        end
        3: begin
          write_limit(mcfd_pkg::CfgMaxSpeed, 8'd0);
          write_limit(mcfd_pkg::CfgMaxAngle, 8'd99);
        end
        default: begin
          write_limit(mcfd_pkg::CfgMaxSpeed, 8'($urandom_range(0, 199)));
          write_limit(mcfd_pkg::CfgMaxAngle, 8'($urandom_range(0, 99)));
        end
      endcase
      target = rx_items + RandomBytes / PhaseCount;
      while (rx_items < target) send_random_frame();
      drain_results();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
